FILE: hw/rtl/dta_pkg.sv
// Shared types, widths and codes for the differential thrust allocator.
// No dependencies; every other file imports this package.
package dta_pkg;

    localparam int FORCE_WIDTH = 20;
    localparam int LIM_W       = FORCE_WIDTH - 1;
    localparam int GAIN_W      = 16;
    localparam int CMD_W       = 16;
    localparam int QUO_W       = LIM_W;
    localparam int PROD_W      = FORCE_WIDTH + LIM_W;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // Mixing: base = surge << MIX_FRAC, result >> MIX_SH; commands >> CMD_SH.
    localparam int MIX_FRAC = 12;
    localparam int MIX_SH   = 13;
    localparam int CMD_SH   = 6;

    localparam int FRONT_STAGES = 3;
    localparam int MIX_STAGES   = 4;
    localparam int DTA_LATENCY  = FRONT_STAGES + QUO_W + MIX_STAGES;

    typedef enum logic [1:0] {
        MODE_PASS     = 2'd0,
        MODE_SCALED   = 2'd1,
        MODE_OVERRIDE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_HEADING = 3'd0,
        REG_FWD     = 3'd1,
        REG_REV     = 3'd2,
        REG_MOMENT  = 3'd3,
        REG_IHB     = 3'd4,
        REG_IFS     = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        SCL_NONE   = 2'd0,
        SCL_MOMENT = 2'd1,
        SCL_SURGE  = 2'd2
    } t_scale;

    typedef struct packed {
        logic [LIM_W-1:0]  heading;
        logic [LIM_W-1:0]  fwd;
        logic [LIM_W-1:0]  rev;
        logic [LIM_W-1:0]  moment;
        logic [GAIN_W-1:0] ihb;
        logic [GAIN_W-1:0] ifs;
    } t_cfg;

    // Travels beside the divider: what to do with the quotient.
    typedef struct packed {
        t_mode                   mode;
        t_scale                  sel;
        logic                    neg;
        logic [FORCE_WIDTH-1:0]  s_val;
        logic [FORCE_WIDTH-1:0]  m_val;
    } t_side;

endpackage

FILE: hw/rtl/dta_if.sv
// Valid/ready stream interfaces for commands in and thrusts out.
// Depends on dta_pkg for field widths.
interface dta_cmd_if import dta_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [FORCE_WIDTH-1:0] surge_force;
    logic signed [FORCE_WIDTH-1:0] yaw_moment;

    modport source (output valid, surge_force, yaw_moment, input ready);
    modport sink   (input valid, surge_force, yaw_moment, output ready);
endinterface

interface dta_thr_if import dta_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [FORCE_WIDTH-1:0] first_thrust;
    logic signed [FORCE_WIDTH-1:0] second_thrust;
    logic signed [CMD_W-1:0]       first_command;
    logic signed [CMD_W-1:0]       second_command;
    logic [1:0]                    limit_mode;
    logic                          output_clipped;

    modport source (output valid, first_thrust, second_thrust, first_command,
                    second_command, limit_mode, output_clipped, input ready);
    modport sink   (input valid, first_thrust, second_thrust, first_command,
                    second_command, limit_mode, output_clipped, output ready);
endinterface

FILE: hw/rtl/differential_thrust_allocator.sv
// Pipeline: 3 front stages, 19 divider stages at one quotient bit each and
// 4 mixing stages lie between an accepted command and its result.
// Throughput: one item per cycle without back-pressure; every stage advances
// when its successor frees, so bubbles close up under output back-pressure.
// Reset: synchronous active-low i_rst_n empties the pipeline and loads the
// register defaults; there is no clearing pass.
module differential_thrust_allocator import dta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dta_cmd_if.sink           i_cmd,
    dta_thr_if.source         o_thr,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg                   r_cfg;
    t_reg_idx               w_idx;
    logic                   w_wr;

    logic                   w_f_valid, w_f_ready;
    logic [PROD_W-1:0]      w_f_num;
    logic [FORCE_WIDTH-1:0] w_f_den;
    t_side                  w_f_side;
    logic                   w_d_valid, w_d_ready;
    logic [QUO_W-1:0]       w_d_quo;
    t_side                  w_d_side;
    t_mode                  w_mode;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heading <= LIM_W'(2400);
            r_cfg.fwd     <= LIM_W'(6720);
            r_cfg.rev     <= LIM_W'(4800);
            r_cfg.moment  <= LIM_W'(5760);
            r_cfg.ihb     <= GAIN_W'(4096);
            r_cfg.ifs     <= GAIN_W'(312);
        end else if (w_wr) begin
            case (w_idx)
                REG_HEADING: r_cfg.heading <= pwdata[LIM_W-1:0];
                REG_FWD:     r_cfg.fwd     <= pwdata[LIM_W-1:0];
                REG_REV:     r_cfg.rev     <= pwdata[LIM_W-1:0];
                REG_MOMENT:  r_cfg.moment  <= pwdata[LIM_W-1:0];
                REG_IHB:     r_cfg.ihb     <= pwdata[GAIN_W-1:0];
                REG_IFS:     r_cfg.ifs     <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_HEADING: prdata = DATA_W'(r_cfg.heading);
            REG_FWD:     prdata = DATA_W'(r_cfg.fwd);
            REG_REV:     prdata = DATA_W'(r_cfg.rev);
            REG_MOMENT:  prdata = DATA_W'(r_cfg.moment);
            REG_IHB:     prdata = DATA_W'(r_cfg.ihb);
            REG_IFS:     prdata = DATA_W'(r_cfg.ifs);
            default:     prdata = '0;
        endcase
    end

    dta_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_cmd.valid),
        .o_ready (i_cmd.ready),
        .i_surge (i_cmd.surge_force),
        .i_yaw   (i_cmd.yaw_moment),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_num   (w_f_num),
        .o_den   (w_f_den),
        .o_side  (w_f_side)
    );

    dta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_num   (w_f_num),
        .i_den   (w_f_den),
        .i_side  (w_f_side),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_quo   (w_d_quo),
        .o_side  (w_d_side)
    );

    dta_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_quo   (w_d_quo),
        .i_side  (w_d_side),
        .o_valid (o_thr.valid),
        .i_ready (o_thr.ready),
        .o_t1    (o_thr.first_thrust),
        .o_t2    (o_thr.second_thrust),
        .o_c1    (o_thr.first_command),
        .o_c2    (o_thr.second_command),
        .o_mode  (w_mode),
        .o_clip  (o_thr.output_clipped)
    );

    assign o_thr.limit_mode = w_mode;

endmodule

FILE: hw/rtl/dta_front.sv
// Front end: limit tests, cross products and dominance selection (3 stages).
// Depends on dta_pkg; feeds dta_div.
module dta_front import dta_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [FORCE_WIDTH-1:0] i_surge,
    input  logic [FORCE_WIDTH-1:0] i_yaw,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [PROD_W-1:0]      o_num,
    output logic [FORCE_WIDTH-1:0] o_den,
    output t_side                  o_side
);

    // stage A
    logic                   r_a_v;
    logic [FORCE_WIDTH-1:0] r_a_s, r_a_m, r_a_smag, r_a_mmag;
    logic [LIM_W-1:0]       r_a_flim;
    logic                   r_a_ovr, r_a_sover, r_a_mover;
    // stage B
    logic                   r_b_v;
    logic [FORCE_WIDTH-1:0] r_b_s, r_b_m, r_b_smag, r_b_mmag;
    logic [LIM_W-1:0]       r_b_flim;
    logic                   r_b_ovr, r_b_sover, r_b_mover;
    logic [PROD_W-1:0]      r_b_pa, r_b_pb;
    // stage C
    logic                   r_c_v;
    logic [PROD_W-1:0]      r_c_num;
    logic [FORCE_WIDTH-1:0] r_c_den;
    t_side                  r_c_side;

    logic                   w_en_a, w_en_b, w_en_c;
    logic [FORCE_WIDTH-1:0] w_smag, w_mmag;
    logic [LIM_W-1:0]       w_flim;

    logic [PROD_W-1:0]      n_num;
    logic [FORCE_WIDTH-1:0] n_den;
    t_side                  n_side;
    logic [FORCE_WIDTH-1:0] w_s_cl, w_m_cl;
    logic                   w_sneg, w_mneg;

    assign w_en_c  = ~r_c_v | i_ready;
    assign w_en_b  = ~r_b_v | w_en_c;
    assign w_en_a  = ~r_a_v | w_en_b;
    assign o_ready = w_en_a;

    assign w_smag = i_surge[FORCE_WIDTH-1] ? (~i_surge + 1'b1) : i_surge;
    assign w_mmag = i_yaw[FORCE_WIDTH-1]   ? (~i_yaw + 1'b1)   : i_yaw;
    assign w_flim = i_surge[FORCE_WIDTH-1] ? i_cfg.rev : i_cfg.fwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en_a) begin
            r_a_v <= i_valid;
        end
        if (w_en_a && i_valid) begin
            r_a_s     <= i_surge;
            r_a_m     <= i_yaw;
            r_a_smag  <= w_smag;
            r_a_mmag  <= w_mmag;
            r_a_flim  <= w_flim;
            r_a_ovr   <= w_mmag > {1'b0, i_cfg.heading};
            r_a_sover <= w_smag > {1'b0, w_flim};
            r_a_mover <= w_mmag > {1'b0, i_cfg.moment};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en_b) begin
            r_b_v <= r_a_v;
        end
        if (w_en_b && r_a_v) begin
            r_b_s     <= r_a_s;
            r_b_m     <= r_a_m;
            r_b_smag  <= r_a_smag;
            r_b_mmag  <= r_a_mmag;
            r_b_flim  <= r_a_flim;
            r_b_ovr   <= r_a_ovr;
            r_b_sover <= r_a_sover;
            r_b_mover <= r_a_mover;
            r_b_pa    <= r_a_smag * i_cfg.moment;
            r_b_pb    <= r_a_mmag * r_a_flim;
        end
    end

    // Pick the dominant value: cross products compare overshoot ratios.
    always_comb begin
        w_sneg = r_b_s[FORCE_WIDTH-1];
        w_mneg = r_b_m[FORCE_WIDTH-1];
        w_s_cl = w_sneg ? (~{1'b0, r_b_flim} + 1'b1) : {1'b0, r_b_flim};
        w_m_cl = w_mneg ? (~{1'b0, i_cfg.moment} + 1'b1) : {1'b0, i_cfg.moment};
        n_num        = '0;
        n_den        = FORCE_WIDTH'(1);
        n_side.mode  = MODE_PASS;
        n_side.sel   = SCL_NONE;
        n_side.neg   = 1'b0;
        n_side.s_val = r_b_s;
        n_side.m_val = r_b_m;
        if (r_b_ovr) begin
            n_side.mode  = MODE_OVERRIDE;
            n_side.s_val = '0;
        end else if (r_b_sover || r_b_mover) begin
            n_side.mode = MODE_SCALED;
            if (r_b_sover && r_b_mover && (r_b_pa == r_b_pb)) begin
                n_side.s_val = w_s_cl;
                n_side.m_val = w_m_cl;
            end else if (r_b_sover && (!r_b_mover || (r_b_pa > r_b_pb))) begin
                n_side.s_val = w_s_cl;
                n_side.sel   = SCL_MOMENT;
                n_side.neg   = w_mneg;
                n_num        = r_b_pb;
                n_den        = r_b_smag;
            end else begin
                n_side.m_val = w_m_cl;
                n_side.sel   = SCL_SURGE;
                n_side.neg   = w_sneg;
                n_num        = r_b_pa;
                n_den        = r_b_mmag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en_c) begin
            r_c_v <= r_b_v;
        end
        if (w_en_c && r_b_v) begin
            r_c_num  <= n_num;
            r_c_den  <= n_den;
            r_c_side <= n_side;
        end
    end

    assign o_valid = r_c_v;
    assign o_num   = r_c_num;
    assign o_den   = r_c_den;
    assign o_side  = r_c_side;

endmodule

FILE: hw/rtl/dta_div.sv
// Pipelined restoring divider, one quotient bit per stage (QUO_W stages).
// Depends on dta_pkg; quotient always fits QUO_W bits since num < den << QUO_W.
module dta_div import dta_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [PROD_W-1:0]      i_num,
    input  logic [FORCE_WIDTH-1:0] i_den,
    input  t_side                  i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [QUO_W-1:0]       o_quo,
    output t_side                  o_side
);

    logic [QUO_W-1:0]       r_v;
    logic [FORCE_WIDTH-1:0] r_rem [QUO_W];
    logic [FORCE_WIDTH-1:0] r_den [QUO_W];
    logic [QUO_W-1:0]       r_low [QUO_W];
    logic [QUO_W-1:0]       r_quo [QUO_W];
    t_side                  r_side [QUO_W];
    logic [QUO_W:0]         w_en;

    assign w_en[QUO_W] = i_ready;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic                   w_pv;
        logic [FORCE_WIDTH-1:0] w_prem, w_pden;
        logic [QUO_W-1:0]       w_plow, w_pquo;
        t_side                  w_pside;
        logic [FORCE_WIDTH:0]   w_trial, w_diff;
        logic                   w_fit;
        logic [FORCE_WIDTH-1:0] n_rem;
        logic [QUO_W-1:0]       n_quo;

        assign w_en[k] = ~r_v[k] | w_en[k+1];

        if (k == 0) begin : g_head
            assign w_pv    = i_valid;
            assign w_prem  = i_num[PROD_W-1:QUO_W];
            assign w_plow  = i_num[QUO_W-1:0];
            assign w_pden  = i_den;
            assign w_pquo  = '0;
            assign w_pside = i_side;
        end else begin : g_body
            assign w_pv    = r_v[k-1];
            assign w_prem  = r_rem[k-1];
            assign w_plow  = r_low[k-1];
            assign w_pden  = r_den[k-1];
            assign w_pquo  = r_quo[k-1];
            assign w_pside = r_side[k-1];
        end

        assign w_trial = {w_prem, w_plow[QUO_W-1-k]};
        assign w_diff  = w_trial - {1'b0, w_pden};
        assign w_fit   = w_trial >= {1'b0, w_pden};
        assign n_rem   = w_fit ? w_diff[FORCE_WIDTH-1:0] : w_trial[FORCE_WIDTH-1:0];
        assign n_quo   = {w_pquo[QUO_W-2:0], w_fit};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_pv;
            end
            if (w_en[k] && w_pv) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_pden;
                r_low[k]  <= w_plow;
                r_quo[k]  <= n_quo;
                r_side[k] <= w_pside;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

FILE: hw/rtl/dta_mix.sv
// Mixer and normalizer: thrust products, rounding, saturation (4 stages).
// Depends on dta_pkg; the last stage is the output register.
module dta_mix import dta_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [QUO_W-1:0]              i_quo,
    input  t_side                         i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [FORCE_WIDTH-1:0] o_t1,
    output logic signed [FORCE_WIDTH-1:0] o_t2,
    output logic signed [CMD_W-1:0]       o_c1,
    output logic signed [CMD_W-1:0]       o_c2,
    output t_mode                         o_mode,
    output logic                          o_clip
);

    localparam int BASE_W  = FORCE_WIDTH + MIX_FRAC;
    localparam int TURN_W  = FORCE_WIDTH + GAIN_W + 1;
    localparam int MIX_W   = TURN_W + 1;
    localparam int RS_W    = MIX_W - MIX_SH;
    localparam int CP_W    = FORCE_WIDTH + GAIN_W + 1;
    localparam int CR_W    = CP_W - CMD_SH;
    localparam int MIX_RND = 1 << (MIX_SH - 1);
    localparam int CMD_RND = 1 << (CMD_SH - 1);

    function automatic logic [FORCE_WIDTH:0] sat_force(input logic [RS_W-1:0] v);
        logic hi_ok;
        hi_ok = (&v[RS_W-1:FORCE_WIDTH-1]) | ~(|v[RS_W-1:FORCE_WIDTH-1]);
        if (hi_ok) begin
            sat_force = {1'b0, v[FORCE_WIDTH-1:0]};
        end else if (v[RS_W-1]) begin
            sat_force = {1'b1, 1'b1, {(FORCE_WIDTH-1){1'b0}}};
        end else begin
            sat_force = {1'b1, 1'b0, {(FORCE_WIDTH-1){1'b1}}};
        end
    endfunction

    function automatic logic [CMD_W:0] sat_cmd(input logic [CR_W-1:0] v);
        logic hi_ok;
        hi_ok = (&v[CR_W-1:CMD_W-1]) | ~(|v[CR_W-1:CMD_W-1]);
        if (hi_ok) begin
            sat_cmd = {1'b0, v[CMD_W-1:0]};
        end else if (v[CR_W-1]) begin
            sat_cmd = {1'b1, 1'b1, {(CMD_W-1){1'b0}}};
        end else begin
            sat_cmd = {1'b1, 1'b0, {(CMD_W-1){1'b1}}};
        end
    endfunction

    // stage E
    logic                     r_e_v;
    logic signed [BASE_W-1:0] r_e_base;
    logic signed [TURN_W-1:0] r_e_turn;
    t_mode                    r_e_mode;
    // stage F
    logic                          r_f_v;
    logic signed [FORCE_WIDTH-1:0] r_f_t1, r_f_t2;
    t_mode                         r_f_mode;
    logic                          r_f_clip;
    // stage G
    logic                          r_g_v;
    logic signed [FORCE_WIDTH-1:0] r_g_t1, r_g_t2;
    logic signed [CP_W-1:0]        r_g_p1, r_g_p2;
    t_mode                         r_g_mode;
    logic                          r_g_clip;
    // stage H (output register)
    logic                          r_h_v;
    logic signed [FORCE_WIDTH-1:0] r_h_t1, r_h_t2;
    logic signed [CMD_W-1:0]       r_h_c1, r_h_c2;
    t_mode                         r_h_mode;
    logic                          r_h_clip;

    logic                          w_en_e, w_en_f, w_en_g, w_en_h;
    logic signed [FORCE_WIDTH-1:0] w_qx, w_s, w_m;
    logic signed [MIX_W-1:0]       w_d1, w_d2;
    logic [FORCE_WIDTH:0]          w_st1, w_st2;
    logic signed [CP_W-1:0]        w_r1, w_r2;
    logic [CMD_W:0]                w_sc1, w_sc2;

    assign w_en_h  = ~r_h_v | i_ready;
    assign w_en_g  = ~r_g_v | w_en_h;
    assign w_en_f  = ~r_f_v | w_en_g;
    assign w_en_e  = ~r_e_v | w_en_f;
    assign o_ready = w_en_e;

    // Apply the quotient to whichever value was scaled.
    assign w_qx = {1'b0, i_quo};
    assign w_s  = (i_side.sel == SCL_SURGE) ? (i_side.neg ? -w_qx : w_qx)
                                            : $signed(i_side.s_val);
    assign w_m  = (i_side.sel == SCL_MOMENT) ? (i_side.neg ? -w_qx : w_qx)
                                             : $signed(i_side.m_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_en_e) begin
            r_e_v <= i_valid;
        end
        if (w_en_e && i_valid) begin
            r_e_base <= {w_s, {MIX_FRAC{1'b0}}};
            r_e_turn <= w_m * $signed({1'b0, i_cfg.ihb});
            r_e_mode <= i_side.mode;
        end
    end

    assign w_d1  = MIX_W'(r_e_base) - MIX_W'(r_e_turn) + MIX_W'(MIX_RND);
    assign w_d2  = MIX_W'(r_e_base) + MIX_W'(r_e_turn) + MIX_W'(MIX_RND);
    assign w_st1 = sat_force(w_d1[MIX_W-1:MIX_SH]);
    assign w_st2 = sat_force(w_d2[MIX_W-1:MIX_SH]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en_f) begin
            r_f_v <= r_e_v;
        end
        if (w_en_f && r_e_v) begin
            r_f_t1   <= w_st1[FORCE_WIDTH-1:0];
            r_f_t2   <= w_st2[FORCE_WIDTH-1:0];
            r_f_clip <= w_st1[FORCE_WIDTH] | w_st2[FORCE_WIDTH];
            r_f_mode <= r_e_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (w_en_g) begin
            r_g_v <= r_f_v;
        end
        if (w_en_g && r_f_v) begin
            r_g_t1   <= r_f_t1;
            r_g_t2   <= r_f_t2;
            r_g_p1   <= r_f_t1 * $signed({1'b0, i_cfg.ifs});
            r_g_p2   <= r_f_t2 * $signed({1'b0, i_cfg.ifs});
            r_g_clip <= r_f_clip;
            r_g_mode <= r_f_mode;
        end
    end

    assign w_r1  = r_g_p1 + CP_W'(CMD_RND);
    assign w_r2  = r_g_p2 + CP_W'(CMD_RND);
    assign w_sc1 = sat_cmd(w_r1[CP_W-1:CMD_SH]);
    assign w_sc2 = sat_cmd(w_r2[CP_W-1:CMD_SH]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (w_en_h) begin
            r_h_v <= r_g_v;
        end
        if (w_en_h && r_g_v) begin
            r_h_t1   <= r_g_t1;
            r_h_t2   <= r_g_t2;
            r_h_c1   <= w_sc1[CMD_W-1:0];
            r_h_c2   <= w_sc2[CMD_W-1:0];
            r_h_clip <= r_g_clip | w_sc1[CMD_W] | w_sc2[CMD_W];
            r_h_mode <= r_g_mode;
        end
    end

    assign o_valid = r_h_v;
    assign o_t1    = r_h_t1;
    assign o_t2    = r_h_t2;
    assign o_c1    = r_h_c1;
    assign o_c2    = r_h_c2;
    assign o_mode  = r_h_mode;
    assign o_clip  = r_h_clip;

endmodule

FILE: hw/rtl/dta_checker.sv
// Port-level checks for the allocator, attached by bind below.
// Depends on dta_pkg for the pipeline depth.
module dta_checker import dta_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [FORCE_WIDTH-1:0] i_out_t1,
    input logic [CMD_W-1:0] i_out_c1
);

    localparam int CNT_W = $clog2(DTA_LATENCY + 1) + 1;

    logic [CNT_W-1:0] r_inflight;
    logic             w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid & i_in_ready;
    assign w_out_acc = i_out_valid & i_out_ready;

    // Count items inside the pipe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CNT_W'(w_in_acc) - CNT_W'(w_out_acc);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_inflight != '0))
        else $error("result without a matching command");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(DTA_LATENCY))
        else $error("more items in flight than pipeline stages");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_t1) && $stable(i_out_c1)))
        else $error("stalled result changed");

endmodule

bind differential_thrust_allocator dta_checker u_dta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_thr.valid),
    .i_out_ready (o_thr.ready),
    .i_out_t1    (o_thr.first_thrust),
    .i_out_c1    (o_thr.first_command)
);

FILE: test/differential_thrust_allocator_test.sv
// Self-checking bench for differential_thrust_allocator: drives commands and
// register writes, predicts each thrust item and compares it at the output.
// Depends on dta_pkg, the dta_cmd_if/dta_thr_if interfaces and the block RTL.
module differential_thrust_allocator_test import dta_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FORCE_MAX = (64'sd1 <<< (FORCE_WIDTH - 1)) - 1;
    localparam longint FORCE_MIN = -(64'sd1 <<< (FORCE_WIDTH - 1));
    localparam longint LIM_MAX   = (64'sd1 <<< LIM_W) - 1;
    localparam longint GAIN_MAX  = (64'sd1 <<< GAIN_W) - 1;
    localparam int     PHASES    = 9;
    localparam int     PHASE_LEN = 225;

    typedef struct {
        logic signed [FORCE_WIDTH-1:0] first_thrust;
        logic signed [FORCE_WIDTH-1:0] second_thrust;
        logic signed [CMD_W-1:0]       first_command;
        logic signed [CMD_W-1:0]       second_command;
        t_mode                         mode;
        logic                          clipped;
    } t_thrust_set;

    class t_thrust_scoreboard;
        longint heading, fwd, rev, moment, ihb, ifs;
        t_thrust_set expected_thrusts[$];
        int failures;

        function new();
            heading = 2400;
            fwd = 6720;
            rev = 4800;
            moment = 5760;
            ihb = 4096;
            ifs = 312;
            failures = 0;
        endfunction

        function void set_register(t_reg_idx idx, longint val);
            case (idx)
                REG_HEADING: heading = val & LIM_MAX;
                REG_FWD:     fwd = val & LIM_MAX;
                REG_REV:     rev = val & LIM_MAX;
                REG_MOMENT:  moment = val & LIM_MAX;
                REG_IHB:     ihb = val & GAIN_MAX;
                REG_IFS:     ifs = val & GAIN_MAX;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_thrusts.size();
        endfunction

        // floor((n + half) / 2^sh)
        function longint round_half_up(longint n, int sh);
            return (n + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        function longint saturate(longint v, int w, inout bit hit);
            longint hi, lo;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -(64'sd1 <<< (w - 1));
            if (v > hi) begin
                hit = 1'b1;
                return hi;
            end
            if (v < lo) begin
                hit = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // v * lim / dom, truncated toward zero, sign of v kept
        function longint rescale(longint v, longint lim, longint dom);
            longint q;
            q = ((v < 0 ? -v : v) * lim) / dom;
            return v < 0 ? -q : q;
        endfunction

        function t_thrust_set allocate(logic signed [FORCE_WIDTH-1:0] surge,
                                       logic signed [FORCE_WIDTH-1:0] yaw);
            t_thrust_set r;
            longint s, m, smag, mmag, flim, a, b, base, turn, t1, t2, c1, c2;
            bit sover, mover, hit;
            t_mode mode;
            s = surge;
            m = yaw;
            smag = s < 0 ? -s : s;
            mmag = m < 0 ? -m : m;
            mode = MODE_PASS;
            hit = 1'b0;
            if (mmag > heading) begin
                s = 0;
                mode = MODE_OVERRIDE;
            end else begin
                flim = s < 0 ? rev : fwd;
                sover = smag > flim;
                mover = mmag > moment;
                if (sover || mover) begin
                    // compare overshoot ratios by cross products
                    a = sover ? smag * moment : 0;
                    b = mover ? mmag * flim : 0;
                    mode = MODE_SCALED;
                    if (sover && mover && a == b) begin
                        s = s < 0 ? -flim : flim;
                        m = m < 0 ? -moment : moment;
                    end else if (sover && (!mover || a > b)) begin
                        m = rescale(m, flim, smag);
                        s = s < 0 ? -flim : flim;
                    end else begin
                        s = rescale(s, moment, mmag);
                        m = m < 0 ? -moment : moment;
                    end
                end
            end
            base = s * (64'sd1 <<< MIX_FRAC);
            turn = m * ihb;
            t1 = saturate(round_half_up(base - turn, MIX_SH), FORCE_WIDTH, hit);
            t2 = saturate(round_half_up(base + turn, MIX_SH), FORCE_WIDTH, hit);
            c1 = saturate(round_half_up(t1 * ifs, CMD_SH), CMD_W, hit);
            c2 = saturate(round_half_up(t2 * ifs, CMD_SH), CMD_W, hit);
            r.first_thrust = t1[FORCE_WIDTH-1:0];
            r.second_thrust = t2[FORCE_WIDTH-1:0];
            r.first_command = c1[CMD_W-1:0];
            r.second_command = c2[CMD_W-1:0];
            r.mode = mode;
            r.clipped = hit;
            return r;
        endfunction

        function void note_command(logic signed [FORCE_WIDTH-1:0] surge,
                                   logic signed [FORCE_WIDTH-1:0] yaw);
            expected_thrusts.push_back(allocate(surge, yaw));
        endfunction

        function void check_thrusts(t_thrust_set got);
            t_thrust_set want;
            if (expected_thrusts.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected thrust item t1=%0d t2=%0d", got.first_thrust,
                             got.second_thrust);
                return;
            end
            want = expected_thrusts.pop_front();
            if (want.first_thrust !== got.first_thrust
                    || want.second_thrust !== got.second_thrust
                    || want.first_command !== got.first_command
                    || want.second_command !== got.second_command
                    || want.mode !== got.mode
                    || want.clipped !== got.clipped) begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch at %0t: exp t=%0d/%0d c=%0d/%0d mode=%0d clip=%0b,",
                              " got t=%0d/%0d c=%0d/%0d mode=%0d clip=%0b"},
                             $realtime, want.first_thrust, want.second_thrust,
                             want.first_command, want.second_command, want.mode,
                             want.clipped, got.first_thrust, got.second_thrust,
                             got.first_command, got.second_command, got.mode,
                             got.clipped);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int send_idle_pct;
    int recv_idle_pct;

    t_thrust_scoreboard sb = new();

    dta_cmd_if cmd_if();
    dta_thr_if thr_if();

    differential_thrust_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_thr   (thr_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL differential_thrust_allocator");
        $finish;
    end

    always @(negedge i_clk) begin
        thr_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : watch_thrusts
        t_thrust_set got;
        if (i_rst_n && thr_if.valid && thr_if.ready) begin
            got.first_thrust = thr_if.first_thrust;
            got.second_thrust = thr_if.second_thrust;
            got.first_command = thr_if.first_command;
            got.second_command = thr_if.second_command;
            got.mode = t_mode'(thr_if.limit_mode);
            got.clipped = thr_if.output_clipped;
            sb.check_thrusts(got);
        end
    end

    function automatic longint clamp_force(longint v);
        if (v > FORCE_MAX) return FORCE_MAX;
        if (v < FORCE_MIN) return FORCE_MIN;
        return v;
    endfunction

    task automatic write_reg(t_reg_idx idx, longint val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val[DATA_W-1:0];
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, val);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Hold off commands until every item in flight has come out, then reprogram.
    task automatic program_limits(longint h, longint f, longint r, longint mo,
                                  longint ihb, longint ifs);
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        write_reg(REG_HEADING, h);
        write_reg(REG_FWD, f);
        write_reg(REG_REV, r);
        write_reg(REG_MOMENT, mo);
        write_reg(REG_IHB, ihb);
        write_reg(REG_IFS, ifs);
    endtask

    task automatic send_command(longint s, longint m);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            cmd_if.surge_force <= FORCE_WIDTH'($urandom);
            cmd_if.yaw_moment <= FORCE_WIDTH'($urandom);
            @(negedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.surge_force <= s[FORCE_WIDTH-1:0];
        cmd_if.yaw_moment <= m[FORCE_WIDTH-1:0];
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(s[FORCE_WIDTH-1:0], m[FORCE_WIDTH-1:0]);
        @(negedge i_clk);
    endtask

    function automatic longint rand_limit();
        case ($urandom_range(3))
            0: return $urandom_range(2000, 1);
            1: return $urandom_range(20000, 1);
            2: return $urandom_range(10000, 2000);
            default: return $urandom_range(LIM_MAX, 1);
        endcase
    endfunction

    task automatic rand_settings();
        longint f, r, mo, h, ihb, ifs;
        f = rand_limit();
        r = rand_limit();
        mo = rand_limit();
        // keep the heading limit above the moment limit most of the time
        if ($urandom_range(3) == 0)
            h = $urandom_range(LIM_MAX, 0);
        else
            h = mo + $urandom_range(mo, 0);
        if (h > LIM_MAX) h = LIM_MAX;
        ihb = $urandom_range(1) ? $urandom_range(8192, 1) : $urandom_range(GAIN_MAX, 1);
        ifs = $urandom_range(1) ? $urandom_range(1024, 1) : $urandom_range(GAIN_MAX, 1);
        program_limits(h, f, r, mo, ihb, ifs);
    endtask

    task automatic send_random();
        longint s, m, fl, top;
        int k;
        bit sneg, mneg;
        sneg = $urandom_range(1);
        mneg = $urandom_range(1);
        fl = sneg ? sb.rev : sb.fwd;
        top = sb.heading < 3 * sb.moment ? sb.heading : 3 * sb.moment;
        case ($urandom_range(9))
            0: begin
                s = $signed(FORCE_WIDTH'($urandom));
                m = $signed(FORCE_WIDTH'($urandom));
            end
            1: begin
                s = fl + $urandom_range(2) - 1;
                m = $urandom_range(sb.heading, 0);
            end
            2: begin
                s = $urandom_range(2 * fl, 0);
                m = sb.heading + $urandom_range(2) - 1;
            end
            3: begin
                s = $urandom_range(fl, 0);
                m = sb.moment + $urandom_range(2) - 1;
            end
            4: begin
                k = $urandom_range(4, 2);
                s = fl * k;
                m = sb.moment * k;
            end
            default: begin
                s = $urandom_range(3 * fl, 0);
                m = $urandom_range(top, 0);
            end
        endcase
        if (sneg) s = -s;
        if (mneg) m = -m;
        send_command(clamp_force(s), clamp_force(m));
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.surge_force = '0;
        cmd_if.yaw_moment = '0;
        thr_if.ready = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 82;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limits: extremes, heading edge, surge edges
        send_command(0, 0);
        send_command(FORCE_MAX, 0);
        send_command(FORCE_MIN, 0);
        send_command(0, 2400);
        send_command(0, -2400);
        send_command(0, 2401);
        send_command(0, -2401);
        send_command(6720, 100);
        send_command(6721, 100);
        send_command(-4800, -100);
        send_command(-4801, -100);
        send_command(FORCE_MAX, FORCE_MAX);
        send_command(FORCE_MIN, FORCE_MIN);
        send_command(FORCE_MAX, FORCE_MIN);

        // lift the heading limit so both values can overshoot
        program_limits(LIM_MAX, 6720, 4800, 5760, 4096, 312);
        send_command(13440, 11520);
        send_command(-9600, -11520);
        send_command(13440, -11520);
        send_command(-9600, 11520);
        send_command(20000, 6000);
        send_command(7000, 30000);
        send_command(1000, 5760);
        send_command(1000, -5761);
        send_command(FORCE_MIN, FORCE_MAX);
        send_command(FORCE_MAX, FORCE_MIN);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 24;
                recv_idle_pct = 82;
            end else if (ph < 6) begin
                send_idle_pct = 82;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: program_limits(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, GAIN_MAX, GAIN_MAX);
                1: program_limits(0, 1, 1, 1, 1, 1);
                5: program_limits(2400, 6720, 4800, 5760, 4096, 312);
                default: rand_settings();
            endcase
            repeat (PHASE_LEN) send_random();
        end

        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DTA_LATENCY + 4) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS differential_thrust_allocator");
        else
            $display("FAIL differential_thrust_allocator");
        $finish;
    end

endmodule
